// ===== rtl/klle_pkg.sv =====
package klle_pkg;

    typedef enum logic [2:0] {
        OP_HEAD   = 3'd0,
        OP_TAIL   = 3'd1,
        OP_AFTER  = 3'd2,
        OP_BEFORE = 3'd3,
        OP_SEARCH = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_req;     // capture request word, start walk at head (tail insert starts behind the tail)
        logic step;         // advance walk: prev <= cur, cur <= link[cur]
        logic link_new;     // write new node, link it in behind prev or at head
        logic find_hit;     // capture record at cur
    } klle_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cur_nil;
        logic cur_match;
        logic pool_full;
        logic walk_done;
    } klle_stat_t;

endpackage

// ===== rtl/keyed_linked_list_engine.sv =====
// Keyed linked list engine: ordered singly linked list of keyed records in a
// pool of POOL_NODES nodes with a free chain.
// Input channel (in_valid/in_ready) takes one request word: op, new_key,
// new_payload, target_key. Output channel (out_valid/out_ready) returns one
// result word per request: status, found_key, found_payload.
// Head and tail insert need no walk (a tail pointer is kept) and are refused
// on a full pool before any write; search and insert after or before walk
// from the head to the matching node, and on a full pool an insert after or
// before is refused once its target is found. A missing target ends the walk
// at the end of the list. The walk reads one node per cycle from the pool.
// One request is in flight at a time; the next is accepted in the cycle
// after the result word is taken.
// Reset: list empty, free chain covers the whole pool in index order.
// A stalled receiver holds the result word steady; no new request is
// accepted until it is taken.
module keyed_linked_list_engine #(
    parameter int POOL_NODES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic signed [31:0] new_key,
    input  logic [63:0]        new_payload,
    input  logic signed [31:0] target_key,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] found_key,
    output logic [63:0]        found_payload
);
    import klle_pkg::*;

    klle_cmd_t          cmd;
    klle_stat_t         stat;
    logic [2:0]         op_q;
    logic [1:0]         status_q;
    logic               hit_q;
    logic signed [31:0] hit_key;
    logic [63:0]        hit_payload;

    klle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .op_q      (op_q),
        .stat      (stat),
        .cmd       (cmd),
        .status_q  (status_q),
        .hit_q     (hit_q)
    );

    klle_datapath #(.POOL_NODES(POOL_NODES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .new_key     (new_key),
        .new_payload (new_payload),
        .target_key  (target_key),
        .cmd         (cmd),
        .stat        (stat),
        .op_q        (op_q),
        .hit_key     (hit_key),
        .hit_payload (hit_payload)
    );

    // zero the record fields unless a search hit
    assign status        = status_q;
    assign found_key     = hit_q ? hit_key : 32'sd0;
    assign found_payload = hit_q ? hit_payload : 64'd0;
endmodule

// ===== rtl/klle_datapath.sv =====
module klle_datapath #(
    parameter int POOL_NODES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           op,
    input  logic signed [31:0]   new_key,
    input  logic [63:0]          new_payload,
    input  logic signed [31:0]   target_key,
    input  klle_pkg::klle_cmd_t  cmd,
    output klle_pkg::klle_stat_t stat,
    output logic [2:0]           op_q,
    output logic signed [31:0]   hit_key,
    output logic [63:0]          hit_payload
);
    import klle_pkg::*;

    localparam int IW = $clog2(POOL_NODES + 1);
    localparam int AW = $clog2(POOL_NODES);
    localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

    logic [31:0]   key_mem [POOL_NODES];
    logic [63:0]   pay_mem [POOL_NODES];
    logic [IW-1:0] link_reg [POOL_NODES];
    logic [IW-1:0] head_reg, tail_reg, free_reg, cur_reg, prev_reg;
    logic [IW-1:0] steps_reg;
    logic [2:0]    op_reg;
    logic [31:0]   nkey_reg, tkey_reg;
    logic [63:0]   npay_reg;
    logic [31:0]   hkey_reg;
    logic [63:0]   hpay_reg;
    logic          prev_valid_reg;

    logic [IW-1:0] cur_link;
    logic [IW-1:0] new_succ;
    assign cur_link = (cur_reg == NIL) ? NIL : link_reg[cur_reg[AW-1:0]];
    // successor: head when no predecessor, else prev's old link
    assign new_succ = prev_valid_reg ? link_reg[prev_reg[AW-1:0]] : head_reg;

    assign stat.cur_nil   = (cur_reg == NIL);
    assign stat.cur_match = (cur_reg != NIL) && (key_mem[cur_reg[AW-1:0]] == tkey_reg);
    assign stat.pool_full = (free_reg == NIL);
    assign stat.walk_done = (steps_reg == NIL);
    assign op_q        = op_reg;
    assign hit_key     = hkey_reg;
    assign hit_payload = hpay_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg   <= op;
            nkey_reg <= new_key;
            npay_reg <= new_payload;
            tkey_reg <= target_key;
        end
        if (cmd.link_new)
        begin
            key_mem[free_reg[AW-1:0]] <= nkey_reg;
            pay_mem[free_reg[AW-1:0]] <= npay_reg;
        end
        if (cmd.find_hit)
        begin
            hkey_reg <= key_mem[cur_reg[AW-1:0]];
            hpay_reg <= pay_mem[cur_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_NODES; i++)
                link_reg[i] <= IW'(i + 1);
            head_reg       <= NIL;
            tail_reg       <= NIL;
            free_reg       <= '0;
            cur_reg        <= NIL;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            steps_reg      <= '0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                // tail insert jumps straight to the tail
                if (op == OP_TAIL && tail_reg != NIL)
                begin
                    cur_reg        <= NIL;
                    prev_reg       <= tail_reg;
                    prev_valid_reg <= 1'b1;
                end
                else
                begin
                    cur_reg        <= head_reg;
                    prev_valid_reg <= 1'b0;
                end
                steps_reg <= '0;
            end
            else if (cmd.step)
            begin
                prev_reg       <= cur_reg;
                prev_valid_reg <= 1'b1;
                cur_reg        <= cur_link;
                steps_reg      <= steps_reg + 1'b1;
            end
            if (cmd.link_new)
            begin
                free_reg                    <= link_reg[free_reg[AW-1:0]];
                link_reg[free_reg[AW-1:0]] <= new_succ;
                if (new_succ == NIL)
                    tail_reg <= free_reg;
                if (!prev_valid_reg)
                    head_reg <= free_reg;
                else
                    link_reg[prev_reg[AW-1:0]] <= free_reg;
            end
        end
    end
endmodule

// ===== rtl/klle_ctrl.sv =====
module klle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic [2:0]           op_q,
    input  klle_pkg::klle_stat_t stat,
    output klle_pkg::klle_cmd_t  cmd,
    output logic [1:0]           status_q,
    output logic                 hit_q
);
    import klle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_WALK, S_AFTER_FIX, S_INSERT, S_HIT, S_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] status_reg;
    logic       hit_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status_q  = status_reg;
    assign hit_q     = hit_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load_req = in_valid && in_ready;
        unique case (state_reg)
            S_WALK:
                // before-insert needs cur as the match with prev trailing
                cmd.step = !stat.cur_nil && !stat.cur_match && !stat.walk_done;
            // step once more so the matched node becomes prev
            S_AFTER_FIX: cmd.step = 1'b1;
            S_INSERT:    cmd.link_new = 1'b1;
            S_HIT:       cmd.find_hit = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
            hit_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= S_DISPATCH;
                    end
                S_DISPATCH:
                    priority case (op_q)
                        OP_HEAD, OP_TAIL:
                            if (stat.pool_full)
                            begin
                                status_reg <= ST_FULL;
                                state_reg  <= S_OUT;
                            end
                            else
                                state_reg <= S_INSERT;
                        OP_AFTER, OP_BEFORE, OP_SEARCH:
                            state_reg <= S_WALK;
                        default:
                        begin
                            status_reg <= ST_NOTFOUND;
                            state_reg  <= S_OUT;
                        end
                    endcase
                S_WALK:
                    if (stat.cur_match)
                    begin
                        if (op_q == OP_SEARCH)
                        begin
                            status_reg <= ST_OK;
                            hit_reg    <= 1'b1;
                            state_reg  <= S_HIT;
                        end
                        else if (stat.pool_full)
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_OUT;
                        end
                        else if (op_q == OP_AFTER)
                            state_reg <= S_AFTER_FIX;
                        else
                            state_reg <= S_INSERT;
                    end
                    else if (stat.cur_nil || stat.walk_done)
                    begin
                        status_reg <= ST_NOTFOUND;
                        state_reg  <= S_OUT;
                    end
                S_AFTER_FIX:
                    state_reg <= S_INSERT;
                S_INSERT:
                begin
                    status_reg <= ST_OK;
                    state_reg  <= S_OUT;
                end
                S_HIT:
                    state_reg <= S_OUT;
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
